// ===== hdl/pose_weighted_history_smoother_defines.svh =====
// assertion macros for the pose weighted history smoother
// used by the port checker, no other dependencies
`ifndef POSE_WEIGHTED_HISTORY_SMOOTHER_DEFINES_SVH
`define POSE_WEIGHTED_HISTORY_SMOOTHER_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define PWHS_ASSERT_NOW(LBL, ANTE, CONS) \
    LBL: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ANTE) |-> (CONS)) \
        else $error("pose smoother check failed");

// consequent checked in the cycle after the antecedent
`define PWHS_ASSERT_NEXT(LBL, ANTE, CONS) \
    LBL: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ANTE) |=> (CONS)) \
        else $error("pose smoother check failed");

`endif

// ===== hdl/pwhs_pkg.sv =====
// shared types and constants of the pose weighted history smoother
// no dependencies
package pwhs_pkg;

    // axes of one pose, rotation first
    localparam int NUM_AXES  = 6;
    localparam int AX_ROT_X  = 0;
    localparam int AX_ROT_Y  = 1;
    localparam int AX_ROT_Z  = 2;
    localparam int AX_TRN_X  = 3;
    localparam int AX_TRN_Y  = 4;
    localparam int AX_TRN_Z  = 5;

    // weight taps, newest entry uses the last tap
    localparam int NUM_TAPS  = 5;
    localparam int TAP_W     = 17;
    localparam int LIMIT_W   = 16;
    localparam int FRAC_BITS = 16;
    localparam int CFG_IDX_W = 3;

    typedef logic [TAP_W-1:0] t_weight;

    localparam t_weight TAP_RESET [NUM_TAPS] = '{
        17'd3277, 17'd3277, 17'd6554, 17'd19661, 17'd32768
    };
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd2621;

    // configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TAP0  = 3'd0,
        REG_TAP1  = 3'd1,
        REG_TAP2  = 3'd2,
        REG_TAP3  = 3'd3,
        REG_TAP4  = 3'd4,
        REG_LIMIT = 3'd5
    } t_cfg_idx;

    // pipeline control shared by all lanes
    typedef struct packed {
        logic accept;
        logic single;
        logic fill;
        logic load2;
        logic load3;
        logic load4;
        logic load5;
    } t_lane_ctl;

    // last stage to output register
    typedef struct packed {
        logic load;
        logic single;
    } t_merge_ctl;

    // output register status back to the pipeline
    typedef struct packed {
        logic free;
        logic outlier;
    } t_merge_stat;

endpackage

// ===== hdl/pose_weighted_history_smoother.sv =====
// top level of the pose weighted history smoother: config registers,
// pipeline control, six axis lanes and the merge stage
// depends on pwhs_pkg, pwhs_lane, pwhs_merge
//
// Usage
//   Input channel (i_valid / o_stall): one word per camera frame, a pose
//   of six signed Q16.16 values plus the single detection flag.
//   Output channel (o_valid / i_stall): one word per input word, in order.
//   Config channel (i_cfg_valid / o_cfg_ready): ready is always high;
//   index 0..4 are the weight taps, 5 the deviation limit, 6 and 7 are
//   ignored. Write only while the block holds no word.
//   Throughput: words without a single detection go one per cycle while
//   no stall holds the pipeline. A single detection is held off while an
//   earlier one is still in the five-stage pipeline, since its outlier
//   verdict decides whether the history is refilled.
//   Stall: the output register holds its word; the pipeline keeps
//   taking words until every stage is full, then raises o_stall.
//   Reset: synchronous, active low; pipeline emptied, history marked
//   empty, weights and limit back to their defaults.
module pose_weighted_history_smoother
    import pwhs_pkg::*;
#(
    parameter int HISTORY_DEPTH = 5,
    parameter int VALUE_WIDTH   = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_single_detection,
    input  logic signed [VALUE_WIDTH-1:0] i_rot_x,
    input  logic signed [VALUE_WIDTH-1:0] i_rot_y,
    input  logic signed [VALUE_WIDTH-1:0] i_rot_z,
    input  logic signed [VALUE_WIDTH-1:0] i_trans_x,
    input  logic signed [VALUE_WIDTH-1:0] i_trans_y,
    input  logic signed [VALUE_WIDTH-1:0] i_trans_z,
    // output channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [VALUE_WIDTH-1:0] o_out_rot_x,
    output logic signed [VALUE_WIDTH-1:0] o_out_rot_y,
    output logic signed [VALUE_WIDTH-1:0] o_out_rot_z,
    output logic signed [VALUE_WIDTH-1:0] o_out_trans_x,
    output logic signed [VALUE_WIDTH-1:0] o_out_trans_y,
    output logic signed [VALUE_WIDTH-1:0] o_out_trans_z,
    output logic                          o_smoothed,
    output logic                          o_history_cleared,
    // config channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [TAP_W-1:0]              i_cfg_data
);

    localparam int NUM_STAGES = 5;

    t_weight                       r_weight [NUM_TAPS];
    logic [LIMIT_W-1:0]            r_limit;
    logic                          r_hist_empty;
    logic [NUM_STAGES-1:0]         r_v, r_s;
    logic [NUM_STAGES-1:0]         n_free, n_move;
    logic                          n_pending, n_accept;
    t_lane_ctl                     w_lane_ctl;
    t_merge_ctl                    w_merge_ctl;
    t_merge_stat                   w_merge_stat;
    logic signed [VALUE_WIDTH-1:0] w_pose  [NUM_AXES];
    logic signed [VALUE_WIDTH-1:0] w_avg   [NUM_AXES];
    logic signed [VALUE_WIDTH-1:0] w_value [NUM_AXES];
    logic signed [VALUE_WIDTH-1:0] w_out   [NUM_AXES];
    logic [NUM_AXES-1:0]           w_ok;

    // config register writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= TAP_RESET;
            r_limit  <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                REG_TAP0:  r_weight[0] <= i_cfg_data;
                REG_TAP1:  r_weight[1] <= i_cfg_data;
                REG_TAP2:  r_weight[2] <= i_cfg_data;
                REG_TAP3:  r_weight[3] <= i_cfg_data;
                REG_TAP4:  r_weight[4] <= i_cfg_data;
                REG_LIMIT: r_limit     <= i_cfg_data[LIMIT_W-1:0];
                default:   ;
            endcase
        end
    end

    // stage flow: a stage frees up when empty or when its word moves on
    always_comb begin
        n_free[NUM_STAGES-1] = !r_v[NUM_STAGES-1] || w_merge_stat.free;
        n_move[NUM_STAGES-1] = r_v[NUM_STAGES-1] && w_merge_stat.free;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            n_free[k] = !r_v[k] || n_free[k + 1];
            n_move[k] = r_v[k] && n_free[k + 1];
        end
        // a single detection waits for the verdict of the one before it
        n_pending = |(r_v & r_s);
        o_stall   = !n_free[0] || (i_single_detection && n_pending);
        n_accept  = i_valid && !o_stall;
    end

    // stage valid and single-detection flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
            r_s <= '0;
        end else begin
            if (n_free[0]) begin
                r_v[0] <= n_accept;
                r_s[0] <= i_single_detection;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (n_free[k]) begin
                    r_v[k] <= r_v[k - 1];
                    r_s[k] <= r_s[k - 1];
                end
            end
        end
    end

    // history empty flag, settled when a single detection leaves the pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_empty <= 1'b1;
        end else if (n_move[NUM_STAGES-1] && r_s[NUM_STAGES-1]) begin
            r_hist_empty <= w_merge_stat.outlier;
        end
    end

    // lane control
    always_comb begin
        w_lane_ctl.accept  = n_accept;
        w_lane_ctl.single  = i_single_detection;
        w_lane_ctl.fill    = r_hist_empty;
        w_lane_ctl.load2   = n_move[0];
        w_lane_ctl.load3   = n_move[1];
        w_lane_ctl.load4   = n_move[2];
        w_lane_ctl.load5   = n_move[3];
        w_merge_ctl.load   = n_move[NUM_STAGES-1];
        w_merge_ctl.single = r_s[NUM_STAGES-1];
    end

    // pose word to lanes
    assign w_pose[AX_ROT_X] = i_rot_x;
    assign w_pose[AX_ROT_Y] = i_rot_y;
    assign w_pose[AX_ROT_Z] = i_rot_z;
    assign w_pose[AX_TRN_X] = i_trans_x;
    assign w_pose[AX_TRN_Y] = i_trans_y;
    assign w_pose[AX_TRN_Z] = i_trans_z;

    // one lane per axis
    for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
        pwhs_lane #(
            .HISTORY_DEPTH (HISTORY_DEPTH),
            .VALUE_WIDTH   (VALUE_WIDTH)
        ) u_lane (
            .i_clk    (i_clk),
            .i_ctl    (w_lane_ctl),
            .i_weight (r_weight),
            .i_limit  (r_limit),
            .i_value  (w_pose[a]),
            .o_ok     (w_ok[a]),
            .o_avg    (w_avg[a]),
            .o_value  (w_value[a])
        );
    end

    // lane verdicts merged into the output word
    pwhs_merge #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_merge (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (w_merge_ctl),
        .i_ok              (w_ok),
        .i_avg             (w_avg),
        .i_value           (w_value),
        .i_stall           (i_stall),
        .o_stat            (w_merge_stat),
        .o_valid           (o_valid),
        .o_pose            (w_out),
        .o_smoothed        (o_smoothed),
        .o_history_cleared (o_history_cleared)
    );

    assign o_out_rot_x   = w_out[AX_ROT_X];
    assign o_out_rot_y   = w_out[AX_ROT_Y];
    assign o_out_rot_z   = w_out[AX_ROT_Z];
    assign o_out_trans_x = w_out[AX_TRN_X];
    assign o_out_trans_y = w_out[AX_TRN_Y];
    assign o_out_trans_z = w_out[AX_TRN_Z];

endmodule

// ===== hdl/pwhs_lane.sv =====
// one axis lane: history shift line, tap multipliers, adder tree, rounding,
// saturation and deviation test; depends on pwhs_pkg
module pwhs_lane
    import pwhs_pkg::*;
#(
    parameter int HISTORY_DEPTH = 5,
    parameter int VALUE_WIDTH   = 32
) (
    input  logic                          i_clk,
    input  t_lane_ctl                     i_ctl,
    input  t_weight                       i_weight [NUM_TAPS],
    input  logic [LIMIT_W-1:0]            i_limit,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                          o_ok,
    output logic signed [VALUE_WIDTH-1:0] o_avg,
    output logic signed [VALUE_WIDTH-1:0] o_value
);

    localparam int NT    = (HISTORY_DEPTH < NUM_TAPS) ? HISTORY_DEPTH : NUM_TAPS;
    localparam int FIRST = HISTORY_DEPTH - NT;
    localparam int NP    = (NT + 1) / 2;
    localparam int NPROD = 2 * NP;
    localparam int PW    = VALUE_WIDTH + TAP_W + 1;
    localparam int SW    = PW + 3;
    localparam int DW    = VALUE_WIDTH + 1;
    localparam int TW    = SW - FRAC_BITS - VALUE_WIDTH + 1;
    localparam logic signed [SW-1:0] ROUND_HALF =
        {{(SW - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
    localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH - 1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH - 1){1'b0}}};

    logic signed [VALUE_WIDTH-1:0] r_hist [HISTORY_DEPTH];
    logic signed [VALUE_WIDTH-1:0] n_hist [HISTORY_DEPTH];
    logic signed [VALUE_WIDTH-1:0] r_pose1, r_pose2, r_pose3, r_pose4, r_pose5;
    logic signed [PW-1:0]          r_prod [NPROD];
    logic signed [PW-1:0]          n_prod [NPROD];
    logic signed [SW-1:0]          r_pair [NP];
    logic signed [SW-1:0]          n_pair [NP];
    logic signed [SW-1:0]          n_total;
    logic [TW-1:0]                 n_top;
    logic signed [VALUE_WIDTH-1:0] n_avg, r_avg4, r_avg5;
    logic signed [DW-1:0]          n_diff, n_neg;
    logic [VALUE_WIDTH-1:0]        n_mag;
    logic                          n_ok, r_ok5;

    // shift in the new pose, or fill the whole line when history is empty
    always_comb begin
        for (int k = 0; k < HISTORY_DEPTH - 1; k++) begin
            n_hist[k] = i_ctl.fill ? i_value : r_hist[k + 1];
        end
        n_hist[HISTORY_DEPTH-1] = i_value;
    end

    // one multiplier per weighted entry, padded to an even count
    for (genvar j = 0; j < NPROD; j++) begin : g_prod
        if (j < NT) begin : g_tap
            assign n_prod[j] = $signed(r_hist[FIRST + j])
                             * $signed({1'b0, i_weight[NUM_TAPS - NT + j]});
        end else begin : g_pad
            assign n_prod[j] = '0;
        end
    end

    // first adder level
    for (genvar j = 0; j < NP; j++) begin : g_pair
        assign n_pair[j] = SW'(r_prod[2 * j]) + SW'(r_prod[2 * j + 1]);
    end

    // final sum with half-up rounding, then saturate to the value range
    always_comb begin
        n_total = ROUND_HALF;
        for (int j = 0; j < NP; j++) begin
            n_total = n_total + r_pair[j];
        end
        n_top = n_total[SW-1:FRAC_BITS+VALUE_WIDTH-1];
        if ((&n_top) || (~|n_top)) begin
            n_avg = n_total[FRAC_BITS+VALUE_WIDTH-1:FRAC_BITS];
        end else if (n_total[SW-1]) begin
            n_avg = VAL_MIN;
        end else begin
            n_avg = VAL_MAX;
        end
    end

    // absolute deviation of the average from the raw pose
    always_comb begin
        n_diff = DW'(r_avg4) - DW'(r_pose4);
        n_neg  = -n_diff;
        n_mag  = n_diff[DW-1] ? n_neg[VALUE_WIDTH-1:0] : n_diff[VALUE_WIDTH-1:0];
        n_ok   = n_mag < VALUE_WIDTH'(i_limit);
    end

    // history line and stage registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_pose1 <= i_value;
            if (i_ctl.single) begin
                r_hist <= n_hist;
            end
        end
        if (i_ctl.load2) begin
            r_prod  <= n_prod;
            r_pose2 <= r_pose1;
        end
        if (i_ctl.load3) begin
            r_pair  <= n_pair;
            r_pose3 <= r_pose2;
        end
        if (i_ctl.load4) begin
            r_avg4  <= n_avg;
            r_pose4 <= r_pose3;
        end
        if (i_ctl.load5) begin
            r_ok5   <= n_ok;
            r_avg5  <= r_avg4;
            r_pose5 <= r_pose4;
        end
    end

    assign o_ok    = r_ok5;
    assign o_avg   = r_avg5;
    assign o_value = r_pose5;

endmodule

// ===== hdl/pwhs_merge.sv =====
// merge stage: combines the six lane verdicts, picks average or raw pose
// and holds the output word; depends on pwhs_pkg
module pwhs_merge
    import pwhs_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_merge_ctl                    i_ctl,
    input  logic [NUM_AXES-1:0]           i_ok,
    input  logic signed [VALUE_WIDTH-1:0] i_avg   [NUM_AXES],
    input  logic signed [VALUE_WIDTH-1:0] i_value [NUM_AXES],
    input  logic                          i_stall,
    output t_merge_stat                   o_stat,
    output logic                          o_valid,
    output logic signed [VALUE_WIDTH-1:0] o_pose  [NUM_AXES],
    output logic                          o_smoothed,
    output logic                          o_history_cleared
);

    logic                          r_valid;
    logic signed [VALUE_WIDTH-1:0] r_pose [NUM_AXES];
    logic                          r_smoothed, r_cleared;
    logic                          n_all_ok, n_smoothed, n_cleared, n_free;

    // all six axes must pass for the average to be used
    always_comb begin
        n_all_ok   = &i_ok;
        n_smoothed = i_ctl.single & n_all_ok;
        n_cleared  = i_ctl.single & ~n_all_ok;
        n_free     = !r_valid || !i_stall;
    end

    // output word valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (n_free) begin
            r_valid <= i_ctl.load;
        end
    end

    // output word payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.load && n_free) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_pose[a] <= n_smoothed ? i_avg[a] : i_value[a];
            end
            r_smoothed <= n_smoothed;
            r_cleared  <= n_cleared;
        end
    end

    assign o_stat.free       = n_free;
    assign o_stat.outlier    = ~n_all_ok;
    assign o_valid           = r_valid;
    assign o_pose            = r_pose;
    assign o_smoothed        = r_smoothed;
    assign o_history_cleared = r_cleared;

endmodule

// ===== hdl/pwhs_checker.sv =====
// port checker for the pose weighted history smoother, bound to the top
// depends on pose_weighted_history_smoother_defines.svh and pwhs_pkg
`include "pose_weighted_history_smoother_defines.svh"

module pwhs_checker
    import pwhs_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          i_single_detection,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic signed [VALUE_WIDTH-1:0] o_out_rot_x,
    input logic signed [VALUE_WIDTH-1:0] o_out_rot_y,
    input logic signed [VALUE_WIDTH-1:0] o_out_rot_z,
    input logic signed [VALUE_WIDTH-1:0] o_out_trans_x,
    input logic signed [VALUE_WIDTH-1:0] o_out_trans_y,
    input logic signed [VALUE_WIDTH-1:0] o_out_trans_z,
    input logic                          o_smoothed,
    input logic                          o_history_cleared
);

    logic [NUM_AXES*VALUE_WIDTH+1:0] w_out_word;
    logic                            w_single_take;

    // whole output word and single detection take
    assign w_out_word    = {o_out_rot_x, o_out_rot_y, o_out_rot_z, o_out_trans_x,
                            o_out_trans_y, o_out_trans_z, o_smoothed, o_history_cleared};
    assign w_single_take = i_valid && !o_stall && i_single_detection;

    // a stalled output word stays put
    `PWHS_ASSERT_NEXT(a_hold_stalled_word, o_valid && i_stall, o_valid && $stable(w_out_word))

    // a word is never both smoothed and an outlier
    `PWHS_ASSERT_NOW(a_flags_exclusive, o_valid, !(o_smoothed && o_history_cleared))

    // two single detections are never taken in consecutive cycles
    `PWHS_ASSERT_NEXT(a_single_interlock, w_single_take, !w_single_take)

endmodule

bind pose_weighted_history_smoother pwhs_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_pwhs_checker (.*);

// ===== bench/tb_pose_weighted_history_smoother.sv =====
// testbench for pose_weighted_history_smoother: directed and random pose streams,
// each output word checked against an in-bench model of the smoothing history
// depends on pwhs_pkg and the pose_weighted_history_smoother top level
module tb_pose_weighted_history_smoother;
    import pwhs_pkg::*;

    localparam int VALUE_W      = 32;
    localparam int HIST_DEPTH   = 5;
    localparam int IDLE_PCT     = 32;
    localparam int DRAIN_CYCLES = 12;
    localparam int TIMEOUT_TU   = 2_000_000;
    localparam int PHASE_WORDS  = 220;
    localparam longint VAL_MAX  = 64'sh7FFF_FFFF;
    localparam longint VAL_MIN  = -VAL_MAX - 1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    // one input word and one output word
    typedef struct packed {
        logic                              single;
        logic [NUM_AXES-1:0][VALUE_W-1:0]  ax;
    } t_pose_word;

    typedef struct packed {
        logic [NUM_AXES-1:0][VALUE_W-1:0]  ax;
        logic                              smoothed;
        logic                              cleared;
    } t_pose_result;

    // block ports
    logic                      i_clk              = 1'b0;
    logic                      i_rst_n            = 1'b0;
    logic                      i_valid            = 1'b0;
    logic                      o_stall;
    logic                      i_single_detection = 1'b0;
    logic signed [VALUE_W-1:0] i_rot_x            = '0;
    logic signed [VALUE_W-1:0] i_rot_y            = '0;
    logic signed [VALUE_W-1:0] i_rot_z            = '0;
    logic signed [VALUE_W-1:0] i_trans_x          = '0;
    logic signed [VALUE_W-1:0] i_trans_y          = '0;
    logic signed [VALUE_W-1:0] i_trans_z          = '0;
    logic                      o_valid;
    logic                      i_stall            = 1'b0;
    logic signed [VALUE_W-1:0] o_out_rot_x;
    logic signed [VALUE_W-1:0] o_out_rot_y;
    logic signed [VALUE_W-1:0] o_out_rot_z;
    logic signed [VALUE_W-1:0] o_out_trans_x;
    logic signed [VALUE_W-1:0] o_out_trans_y;
    logic signed [VALUE_W-1:0] o_out_trans_z;
    logic                      o_smoothed;
    logic                      o_history_cleared;
    logic                      i_cfg_valid        = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index        = '0;
    logic [TAP_W-1:0]          i_cfg_data         = '0;

    // model state: history, flags and register copies
    longint          pose_history [HIST_DEPTH][NUM_AXES];
    bit              history_empty;
    t_weight         tap_weight [NUM_TAPS];
    logic [LIMIT_W-1:0] accept_limit;

    t_pose_result    expected_poses [$];
    t_pose_result    seen_pose;
    t_pose_result    want_pose;
    int              mismatch_count = 0;
    int              word_count     = 0;
    bit              no_gaps        = 1'b0;
    longint          track [NUM_AXES];
    string           axis_label [NUM_AXES] =
        '{"rot_x", "rot_y", "rot_z", "trans_x", "trans_y", "trans_z"};

    pose_weighted_history_smoother #(
        .HISTORY_DEPTH (HIST_DEPTH),
        .VALUE_WIDTH   (VALUE_W)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_single_detection (i_single_detection),
        .i_rot_x            (i_rot_x),
        .i_rot_y            (i_rot_y),
        .i_rot_z            (i_rot_z),
        .i_trans_x          (i_trans_x),
        .i_trans_y          (i_trans_y),
        .i_trans_z          (i_trans_z),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_out_rot_x        (o_out_rot_x),
        .o_out_rot_y        (o_out_rot_y),
        .o_out_rot_z        (o_out_rot_z),
        .o_out_trans_x      (o_out_trans_x),
        .o_out_trans_y      (o_out_trans_y),
        .o_out_trans_z      (o_out_trans_z),
        .o_smoothed         (o_smoothed),
        .o_history_cleared  (o_history_cleared),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // watchdog
    initial begin
        #(TIMEOUT_TU);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic longint clamp_value(input longint v);
        if (v > VAL_MAX) return VAL_MAX;
        if (v < VAL_MIN) return VAL_MIN;
        return v;
    endfunction

    task automatic reset_model();
        tap_weight    = TAP_RESET;
        accept_limit  = LIMIT_RESET;
        history_empty = 1'b1;
        for (int k = 0; k < HIST_DEPTH; k++) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                pose_history[k][a] = 0;
            end
        end
    endtask

    // history update and weighted average with outlier test for one word
    function automatic t_pose_result smooth_pose(input t_pose_word w);
        t_pose_result r;
        longint       pose [NUM_AXES];
        longint       avg [NUM_AXES];
        longint       acc;
        longint       dev;
        bit           close_enough;
        r.ax       = w.ax;
        r.smoothed = 1'b0;
        r.cleared  = 1'b0;
        if (!w.single) return r;
        for (int a = 0; a < NUM_AXES; a++) begin
            pose[a] = longint'($signed(w.ax[a]));
        end
        // empty history is seeded with copies of the pose
        if (history_empty) begin
            for (int k = 0; k < HIST_DEPTH; k++) begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    pose_history[k][a] = pose[a];
                end
            end
            history_empty = 1'b0;
        end
        for (int k = 0; k < HIST_DEPTH - 1; k++) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                pose_history[k][a] = pose_history[k + 1][a];
            end
        end
        for (int a = 0; a < NUM_AXES; a++) begin
            pose_history[HIST_DEPTH - 1][a] = pose[a];
        end
        // exact sum, round half up, saturate; history depth equals tap count
        close_enough = 1'b1;
        for (int a = 0; a < NUM_AXES; a++) begin
            acc = 0;
            for (int k = 0; k < HIST_DEPTH; k++) begin
                acc += pose_history[k][a] * longint'(tap_weight[k]);
            end
            acc    = clamp_value((acc + 64'sd32768) >>> FRAC_BITS);
            avg[a] = acc;
            dev    = acc - pose[a];
            if (dev < 0) dev = -dev;
            if (dev >= longint'(accept_limit)) close_enough = 1'b0;
        end
        if (close_enough) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r.ax[a] = avg[a][VALUE_W-1:0];
            end
            r.smoothed = 1'b1;
        end else begin
            r.cleared     = 1'b1;
            history_empty = 1'b1;
        end
        return r;
    endfunction

    function automatic t_pose_word pose_of(input bit single,
                                           input logic [VALUE_W-1:0] rx, ry, rz,
                                           input logic [VALUE_W-1:0] tx, ty, tz);
        t_pose_word w;
        w.single       = single;
        w.ax[AX_ROT_X] = rx;
        w.ax[AX_ROT_Y] = ry;
        w.ax[AX_ROT_Z] = rz;
        w.ax[AX_TRN_X] = tx;
        w.ax[AX_TRN_Y] = ty;
        w.ax[AX_TRN_Z] = tz;
        return w;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch on output word %0d: %s", word_count, what);
    endtask

    // send one pose word, leaves valid high at the accepting edge
    task automatic send_pose(input t_pose_word w);
        while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid            <= 1'b1;
        i_single_detection <= w.single;
        i_rot_x            <= w.ax[AX_ROT_X];
        i_rot_y            <= w.ax[AX_ROT_Y];
        i_rot_z            <= w.ax[AX_ROT_Z];
        i_trans_x          <= w.ax[AX_TRN_X];
        i_trans_y          <= w.ax[AX_TRN_Y];
        i_trans_z          <= w.ax[AX_TRN_Z];
        do @(posedge i_clk); while (o_stall);
        expected_poses.insert(expected_poses.size(), smooth_pose(w));
    endtask

    // stop sending and let every outstanding word come out
    task automatic wait_drain();
        i_valid <= 1'b0;
        while (expected_poses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // register write, leaves valid high at the accepting edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TAP_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx < NUM_TAPS) begin
            tap_weight[idx] = data;
        end else if (idx == REG_LIMIT) begin
            accept_limit = data[LIMIT_W-1:0];
        end
    endtask

    task automatic set_weights(input t_weight w0, w1, w2, w3, w4,
                               input logic [LIMIT_W-1:0] lim, input bit touch_spare);
        write_reg(REG_TAP0, w0);
        write_reg(REG_TAP1, w1);
        write_reg(REG_TAP2, w2);
        write_reg(REG_TAP3, w3);
        write_reg(REG_TAP4, w4);
        write_reg(REG_LIMIT, {1'b0, lim});
        // unmapped indexes must not disturb anything
        if (touch_spare) begin
            write_reg(REG_SPARE_A, TAP_W'($urandom_range(0, 17'h1FFFF)));
            write_reg(REG_SPARE_B, TAP_W'($urandom_range(0, 17'h1FFFF)));
        end
        i_cfg_valid <= 1'b0;
    endtask

    // reset weights: seeding, outlier clear and refill, saturation, pass-through
    task automatic test_default_weights();
        send_pose(pose_of(1'b1, 0, 0, 0, 0, 0, 0));
        send_pose(pose_of(1'b1, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                          32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        send_pose(pose_of(1'b1, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                          32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        send_pose(pose_of(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                          32'h8000_0001, 32'h7FFF_FFFE, 32'h0000_0000));
        send_pose(pose_of(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_pose(pose_of(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_pose(pose_of(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_pose(pose_of(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_pose(pose_of(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
        send_pose(pose_of(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    endtask

    // half-up rounding, unity, above-one, zero and oldest-only weights
    task automatic test_rounding_and_weights();
        wait_drain();
        set_weights(17'd0, 17'd0, 17'd0, 17'd0, 17'd32768, 16'hFFFF, 1'b0);
        send_pose(pose_of(1'b1, 32'd1, -32'sd1, 32'd3, -32'sd3, 32'd0, 32'd5));
        wait_drain();
        set_weights(17'd0, 17'd0, 17'd0, 17'd0, 17'd65536, 16'hFFFF, 1'b0);
        send_pose(pose_of(1'b1, 32'h1234_5678, 32'hFEDC_BA98, 32'h0000_8000,
                          32'hFFFF_8000, 32'h7FFF_FFFF, 32'h8000_0000));
        wait_drain();
        set_weights(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 16'hFFFF, 1'b0);
        send_pose(pose_of(1'b1, 0, 0, 0, 0, 0, 0));
        send_pose(pose_of(1'b1, 0, 0, 0, 0, 0, 0));
        send_pose(pose_of(1'b1, 1, 1, 1, 1, 1, 1));
        wait_drain();
        set_weights(17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 16'hFFFF, 1'b0);
        send_pose(pose_of(1'b1, 32'd100, -32'sd100, 32'd100, -32'sd100, 32'd100, -32'sd100));
        wait_drain();
        set_weights(17'd65536, 17'd0, 17'd0, 17'd0, 17'd0, 16'hFFFF, 1'b0);
        send_pose(pose_of(1'b1, 7, 7, 7, 7, 7, 7));
        send_pose(pose_of(1'b1, 9, 9, 9, 9, 9, 9));
    endtask

    // zero limit rejects every average, full limit with spare writes
    task automatic test_limit_extremes();
        wait_drain();
        set_weights(TAP_RESET[0], TAP_RESET[1], TAP_RESET[2], TAP_RESET[3], TAP_RESET[4],
                    16'h0000, 1'b0);
        send_pose(pose_of(1'b1, 0, 0, 0, 0, 0, 0));
        send_pose(pose_of(1'b1, 0, 0, 0, 0, 0, 0));
        wait_drain();
        set_weights(TAP_RESET[0], TAP_RESET[1], TAP_RESET[2], TAP_RESET[3], TAP_RESET[4],
                    16'hFFFF, 1'b1);
        send_pose(pose_of(1'b1, 32'h100, 32'h100, 32'h100, 32'h100, 32'h100, 32'h100));
        send_pose(pose_of(1'b1, 32'h200, 32'h200, 32'h200, 32'h200, 32'h200, 32'h200));
    endtask

    // weights and limit for one random phase
    task automatic load_phase_config(input int phase);
        t_weight            w [NUM_TAPS];
        logic [LIMIT_W-1:0] lim;
        int unsigned        left;
        if (phase == 0) begin
            w   = TAP_RESET;
            lim = LIMIT_RESET;
        end else if (phase == 4) begin
            for (int i = 0; i < NUM_TAPS; i++) w[i] = TAP_W'($urandom_range(0, 17'h1FFFF));
            lim = LIMIT_W'($urandom_range(0, 16'hFFFF));
        end else begin
            // weights summing to one so slow tracks mostly smooth
            left = 65536;
            for (int i = 0; i < NUM_TAPS - 1; i++) begin
                w[i] = TAP_W'($urandom_range(0, 16384));
                left -= w[i];
            end
            w[NUM_TAPS - 1] = TAP_W'(left);
            lim = (phase == 3) ? LIMIT_W'($urandom_range(0, 64))
                               : LIMIT_W'($urandom_range(512, 16'hFFFF));
        end
        set_weights(w[0], w[1], w[2], w[3], w[4], lim, phase == 1);
    endtask

    // slowly moving pose tracks with jumps, noise and non-single words
    task automatic run_track_phase(input int n_words);
        int         r;
        int         c;
        longint     step;
        t_pose_word w;
        for (int a = 0; a < NUM_AXES; a++) begin
            c = $urandom_range(0, 3);
            case (c)
                0: track[a] = longint'($urandom_range(0, 32'h0020_0000)) - 64'sh0010_0000;
                1: track[a] = longint'($signed($urandom));
                2: track[a] = VAL_MAX - longint'($urandom_range(0, 4096));
                default: track[a] = VAL_MIN + longint'($urandom_range(0, 4096));
            endcase
        end
        for (int n = 0; n < n_words; n++) begin
            r    = $urandom_range(0, 99);
            step = longint'(accept_limit) >>> $urandom_range(3, 7);
            if (step < 1) step = 1;
            if (r < 12) begin
                w.single = 1'b0;
                for (int a = 0; a < NUM_AXES; a++) w.ax[a] = $urandom;
            end else if (r < 16) begin
                w.single = 1'b1;
                for (int a = 0; a < NUM_AXES; a++) w.ax[a] = $urandom;
            end else begin
                w.single = 1'b1;
                for (int a = 0; a < NUM_AXES; a++) begin
                    if (r < 20) begin
                        track[a] += longint'($urandom_range(0, 32'h0100_0000)) - 64'sh0080_0000;
                    end else begin
                        track[a] += longint'($urandom_range(0, 2 * step)) - step;
                    end
                    track[a] = clamp_value(track[a]);
                    w.ax[a]  = track[a][VALUE_W-1:0];
                end
            end
            send_pose(w);
        end
    endtask

    task automatic test_random_tracks();
        for (int p = 0; p < 6; p++) begin
            wait_drain();
            // one phase runs with no gaps on either side
            no_gaps = (p == 2);
            load_phase_config(p);
            run_track_phase(PHASE_WORDS);
        end
        wait_drain();
        no_gaps = 1'b0;
    endtask

    // output side: random stall and compare against the oldest expected word
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            seen_pose.ax[AX_ROT_X] = o_out_rot_x;
            seen_pose.ax[AX_ROT_Y] = o_out_rot_y;
            seen_pose.ax[AX_ROT_Z] = o_out_rot_z;
            seen_pose.ax[AX_TRN_X] = o_out_trans_x;
            seen_pose.ax[AX_TRN_Y] = o_out_trans_y;
            seen_pose.ax[AX_TRN_Z] = o_out_trans_z;
            seen_pose.smoothed     = o_smoothed;
            seen_pose.cleared      = o_history_cleared;
            if (expected_poses.size() == 0) begin
                report_mismatch("word arrived with nothing expected");
            end else begin
                want_pose = expected_poses[0];
                expected_poses.delete(0);
                for (int a = 0; a < NUM_AXES; a++) begin
                    if (seen_pose.ax[a] !== want_pose.ax[a]) begin
                        report_mismatch($sformatf("%s got %h expected %h", axis_label[a],
                                                  seen_pose.ax[a], want_pose.ax[a]));
                    end
                end
                if (seen_pose.smoothed !== want_pose.smoothed) begin
                    report_mismatch($sformatf("smoothed got %b expected %b",
                                              seen_pose.smoothed, want_pose.smoothed));
                end
                if (seen_pose.cleared !== want_pose.cleared) begin
                    report_mismatch($sformatf("history_cleared got %b expected %b",
                                              seen_pose.cleared, want_pose.cleared));
                end
            end
            word_count++;
        end
        i_stall <= !no_gaps && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // test sequence
    initial begin
        reset_model();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_weights();
        test_rounding_and_weights();
        test_limit_extremes();
        test_random_tracks();
        wait_drain();
        if (mismatch_count == 0 && expected_poses.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/pwhs_pkg.sv
hdl/pwhs_lane.sv
hdl/pwhs_merge.sv
hdl/pose_weighted_history_smoother.sv
hdl/pwhs_checker.sv
bench/tb_pose_weighted_history_smoother.sv
